### sv/por_pkg.sv
// Shared types and constants for the oldest-unreferenced page table.
// No dependencies; used by the cells, the controller, the top level and the checker.
package por_pkg;

	localparam int TAG_W      = 16;
	localparam int CNT_W      = 32;
	localparam int SLOT_W     = 8;   // enough for the largest table (256 entries)
	localparam int OUT_SLOT_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Broadcast commands from the controller to every cell
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_SET_REF,
		CMD_INSTALL,
		CMD_REPLACE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		logic [CNT_W-1:0]  age;
		logic              wr;
	} cmd_t;

	// Search word handed from cell to cell
	typedef struct packed {
		logic              active;
		logic [TAG_W-1:0]  tag;
		logic              hit;
		logic [SLOT_W-1:0] hit_slot;
		logic              cand;
		logic [CNT_W-1:0]  best_time;
		logic [SLOT_W-1:0] best_slot;
	} token_t;

	// Saturating increment of a counter
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

### sv/por_cell.sv
// One table entry: tag, load time and status bits, plus its stage of the search chain.
// Depends on por_pkg.
module por_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  por_pkg::token_t tok_in,
	input  por_pkg::cmd_t   cmd,
	output por_pkg::token_t tok_q
);

	logic [por_pkg::TAG_W-1:0] tag_q;
	logic [por_pkg::CNT_W-1:0] time_q;
	logic                      valid_q;
	logic                      mod_q;
	logic                      ref_q;
	logic                      sel;
	por_pkg::token_t           tok_d;

	assign sel = (cmd.slot == por_pkg::SLOT_W'(IDX));

	// Search step: first matching tag wins, oldest unreferenced entry is the candidate
	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && (tag_q == tok_in.tag)) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_slot = por_pkg::SLOT_W'(IDX);
		end
		if (!ref_q && (!tok_in.cand || (time_q < tok_in.best_time))) begin
			tok_d.cand      = 1'b1;
			tok_d.best_time = time_q;
			tok_d.best_slot = por_pkg::SLOT_W'(IDX);
		end
	end

	// Word handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// Entry tag, load time and status bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mod_q   <= 1'b0;
			ref_q   <= 1'b0;
			tag_q   <= '0;
			time_q  <= '0;
		end else begin
			unique case (cmd.op)
				por_pkg::CMD_NONE: begin
				end
				por_pkg::CMD_SET_REF: begin
					if (sel) ref_q <= 1'b1;
				end
				por_pkg::CMD_INSTALL, por_pkg::CMD_REPLACE: begin
					// replace clears every reference bit, the new page keeps its own set
					if (cmd.op == por_pkg::CMD_REPLACE) ref_q <= sel;
					if (sel) begin
						tag_q   <= cmd.tag;
						time_q  <= cmd.age;
						valid_q <= 1'b1;
						mod_q   <= cmd.wr;
						ref_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/por_ctrl.sv
// Controller: fill pointer, counters, search launch and the result word.
// Depends on por_pkg.
module por_ctrl #(
	parameter int ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [por_pkg::TAG_W-1:0]      page_address,
	input  logic                           is_write,
	input  por_pkg::token_t                tail,
	output por_pkg::token_t                launch,
	output por_pkg::cmd_t                  cmd,
	output logic                           busy,
	output logic                           done,
	output logic                           hit,
	output logic [por_pkg::OUT_SLOT_W-1:0] slot,
	output logic [por_pkg::CNT_W-1:0]      fault_count
);

	localparam int IW = $clog2(ENTRIES);

	por_pkg::state_t           state_q, state_d;
	logic [IW-1:0]             fill_q;
	logic                      full_q;
	logic [por_pkg::CNT_W-1:0] access_q;
	logic [por_pkg::CNT_W-1:0] fault_q;
	logic [por_pkg::TAG_W-1:0] tag_q;
	logic                      wr_q;
	logic [por_pkg::CNT_W-1:0] age_q;
	logic                      done_q;
	logic                      hit_q;
	logic [por_pkg::OUT_SLOT_W-1:0] slot_q;
	logic                      accept;
	logic                      fill_acc;
	logic                      walk_end;

	assign accept   = start && (state_q == por_pkg::ST_IDLE);
	assign fill_acc = accept && !full_q;
	assign walk_end = (state_q == por_pkg::ST_WALK) && tail.active;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			por_pkg::ST_IDLE: if (accept && full_q) state_d = por_pkg::ST_WALK;
			por_pkg::ST_WALK: if (tail.active) state_d = por_pkg::ST_IDLE;
			default:          state_d = por_pkg::ST_IDLE;
		endcase
	end

	// Outputs: busy flag, launch word and broadcast command
	always_comb begin
		busy = (state_q == por_pkg::ST_WALK);

		launch           = '0;
		launch.active    = accept && full_q;
		launch.tag       = page_address;

		cmd      = '0;
		cmd.op   = por_pkg::CMD_NONE;
		if (fill_acc) begin
			cmd.op   = por_pkg::CMD_INSTALL;
			cmd.slot = por_pkg::SLOT_W'(fill_q);
			cmd.tag  = page_address;
			cmd.age  = access_q;
			cmd.wr   = is_write;
		end else if (walk_end) begin
			cmd.tag  = tag_q;
			cmd.age  = age_q;
			cmd.wr   = wr_q;
			if (tail.hit) begin
				cmd.op   = por_pkg::CMD_SET_REF;
				cmd.slot = tail.hit_slot;
			end else begin
				cmd.op   = por_pkg::CMD_REPLACE;
				cmd.slot = tail.best_slot;
			end
		end
	end

	// Control registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= por_pkg::ST_IDLE;
			fill_q   <= '0;
			full_q   <= 1'b0;
			access_q <= '0;
			fault_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fill_acc || walk_end;
			if (accept) access_q <= por_pkg::sat_inc(access_q);
			if (fill_acc || (walk_end && !tail.hit)) fault_q <= por_pkg::sat_inc(fault_q);
			if (fill_acc) begin
				fill_q <= fill_q + IW'(1);
				if (fill_q == IW'(ENTRIES - 1)) full_q <= 1'b1;
			end
		end
	end

	// Access word held for the walk, and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= page_address;
			wr_q  <= is_write;
			age_q <= access_q;
		end
		if (fill_acc || walk_end) begin
			hit_q  <= walk_end && tail.hit;
			slot_q <= cmd.slot[por_pkg::OUT_SLOT_W-1:0];
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign fault_count = fault_q;

endmodule

### sv/page_replacement_oldest_unreferenced_core.sv
// Page table with not-recently-used replacement, oldest load time breaking ties.
// Timing: while the table fills, an access is taken with start and its result word appears
// with done in the next cycle; busy stays low. Once full, each access sends a search word
// down the row of ENTRIES cells, one cell per cycle, and busy stays high while the word
// travels; the result word is registered from the last cell's output. The result is
// shown with done for one cycle only: the receiver must take it then, there is no stall.
// Depends on por_pkg, por_cell and por_ctrl.
module page_replacement_oldest_unreferenced_core #(
	parameter int ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [por_pkg::TAG_W-1:0]      page_address,
	input  logic                           is_write,
	output logic                           done,
	output logic                           hit,
	output logic [por_pkg::OUT_SLOT_W-1:0] slot,
	output logic [por_pkg::CNT_W-1:0]      fault_count
);

	por_pkg::token_t launch;
	por_pkg::token_t chain [ENTRIES];
	por_pkg::cmd_t   cmd;

	// Control and counters
	por_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.page_address(page_address),
		.is_write    (is_write),
		.tail        (chain[ENTRIES-1]),
		.launch      (launch),
		.cmd         (cmd),
		.busy        (busy),
		.done        (done),
		.hit         (hit),
		.slot        (slot),
		.fault_count (fault_count)
	);

	// Row of entry cells, search word flows from cell 0 upwards
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			por_cell #(.IDX(i)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.tok_in(launch),
				.cmd   (cmd),
				.tok_q (chain[i])
			);
		end else begin : g_body
			por_cell #(.IDX(i)) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.tok_in(chain[i-1]),
				.cmd   (cmd),
				.tok_q (chain[i])
			);
		end
	end

endmodule

### sv/por_chk.sv
// Port-level checks on the page table's result word and counters, with its bind.
// Depends on por_pkg and page_replacement_oldest_unreferenced_core.
module por_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           busy,
	input logic                           done,
	input logic                           hit,
	input logic [por_pkg::CNT_W-1:0]      fault_count
);

	// A result never shows while a search is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result word while busy");

	// The end of a search always delivers its result word
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("search ended without a result");

	// A fault adds one to the total unless it is saturated
	a_fault_inc: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit && ($past(fault_count) != por_pkg::CNT_MAX)
		|-> fault_count == $past(fault_count) + por_pkg::CNT_W'(1))
		else $error("fault total not advanced on a fault");

	// A hit leaves the fault total alone
	a_hit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> $stable(fault_count)) else $error("fault total moved on a hit");

endmodule

bind page_replacement_oldest_unreferenced_core por_chk u_por_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.fault_count(fault_count)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_replacement_oldest_unreferenced_core (16-entry table).
// Predicts each result word from its own copy of the page table; depends on por_pkg and the RTL.
module testbench;

	localparam int ENTRIES     = 16;
	localparam int TAG_W       = por_pkg::TAG_W;
	localparam int CNT_W       = por_pkg::CNT_W;
	localparam int OUT_SLOT_W  = por_pkg::OUT_SLOT_W;
	localparam int RANDOM_WORDS = 1400;
	localparam int CALM_WORDS  = 200;     // closing stretch with no idling
	localparam int WATCHDOG_NS = 5_000_000;

	typedef struct {
		logic                  hit;
		logic [OUT_SLOT_W-1:0] slot;
		logic [CNT_W-1:0]      faults;
	} access_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [TAG_W-1:0]      page_address = '0;
	logic                  is_write = 1'b0;
	logic                  done;
	logic                  hit;
	logic [OUT_SLOT_W-1:0] slot;
	logic [CNT_W-1:0]      fault_count;

	// Predicted page table
	logic [TAG_W-1:0] tbl_tag    [ENTRIES] = '{default: '0};
	logic [CNT_W-1:0] tbl_loaded [ENTRIES] = '{default: '0};
	logic             tbl_ref    [ENTRIES] = '{default: 1'b0};
	int               fill_next = 0;
	bit               tbl_full = 1'b0;
	logic [CNT_W-1:0] access_total = '0;
	logic [CNT_W-1:0] fault_total = '0;

	access_result_t pending_results[$];
	int             mismatches = 0;
	bit             idle_enabled = 1'b1;

	page_replacement_oldest_unreferenced_core #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.page_address(page_address),
		.is_write(is_write),
		.done(done),
		.hit(hit),
		.slot(slot),
		.fault_count(fault_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("*** FAILED ***");
		$finish;
	end

	// Work out the result word of one access and update the predicted table
	function automatic access_result_t predict_access(input logic [TAG_W-1:0] addr);
		access_result_t   r;
		int               s;
		int               i;
		bit               found;
		logic [CNT_W-1:0] oldest;
		r.hit = 1'b0;
		s = 0;
		found = 1'b0;
		oldest = '0;
		if (!tbl_full) begin
			// filling: next free slot, no lookup
			s = (fill_next >= ENTRIES) ? 0 : fill_next;
			fill_next = s + 1;
			if (fill_next >= ENTRIES)
				tbl_full = 1'b1;
		end else begin
			// lowest matching entry wins
			for (i = 0; i < ENTRIES; i++) begin
				if (!r.hit && tbl_tag[i] == addr) begin
					tbl_ref[i] = 1'b1;
					s = i;
					r.hit = 1'b1;
				end
			end
			// victim: oldest unreferenced, slot 0 if none; all ref bits cleared
			if (!r.hit) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (!tbl_ref[i] && (!found || tbl_loaded[i] < oldest)) begin
						oldest = tbl_loaded[i];
						s = i;
						found = 1'b1;
					end
					tbl_ref[i] = 1'b0;
				end
			end
		end
		if (!r.hit) begin
			tbl_tag[s] = addr;
			tbl_loaded[s] = access_total;
			tbl_ref[s] = 1'b1;
			if (fault_total != por_pkg::CNT_MAX)
				fault_total = fault_total + CNT_W'(1);
		end
		if (access_total != por_pkg::CNT_MAX)
			access_total = access_total + CNT_W'(1);
		r.slot = OUT_SLOT_W'(s);
		r.faults = fault_total;
		return r;
	endfunction

	// Offer one access word, wait for it to be taken, then maybe idle a burst
	task automatic send_access(input logic [TAG_W-1:0] addr, input logic wr);
		@(negedge clk);
		start <= 1'b1;
		page_address <= addr;
		is_write <= wr;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_access(addr));
		if (idle_enabled && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 15)) @(negedge clk) begin
				start <= 1'b0;
				page_address <= TAG_W'($urandom);
				is_write <= 1'($urandom);
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Result checker: every done word against the oldest prediction
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word: expected none, got hit %0d slot %0d faults %0d",
					$time, hit, slot, fault_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
				check_field("slot", CNT_W'(want.slot), CNT_W'(slot));
				check_field("fault_count", want.faults, fault_count);
			end
		end
	end

	// Fill phase: extremes, a repeated page (still a fault), both access kinds
	task automatic test_fill_phase();
		int k;
		send_access(16'h0000, 1'b0);
		send_access(16'hFFFF, 1'b1);
		send_access(16'h0000, 1'b1);
		send_access(16'h5555, 1'b0);
		send_access(16'hAAAA, 1'b1);
		for (k = 0; k < ENTRIES - 5; k++)
			send_access(16'h0100 + TAG_W'(k), 1'(k));
	endtask

	// Hits once full: duplicate tag hits lowest slot, write hit, plain read hit
	task automatic test_hits();
		send_access(16'h0000, 1'b0);
		send_access(16'hFFFF, 1'b1);
		send_access(16'h0105, 1'b0);
	endtask

	// Misses: all referenced takes slot 0, then oldest unreferenced, then a hit on the duplicate
	task automatic test_replacement();
		send_access(16'h1234, 1'b0);
		send_access(16'h4321, 1'b1);
		send_access(16'h0000, 1'b0);
	endtask

	// Random traffic over a shifting working set, with some wholly random pages
	task automatic test_random_traffic();
		logic [TAG_W-1:0] working_set[32];
		int               set_size;
		int               n;
		int               k;
		logic [TAG_W-1:0] addr;
		set_size = 16;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) begin
				set_size = $urandom_range(10, 28);
				for (k = 0; k < 32; k++)
					working_set[k] = TAG_W'($urandom_range(0, 65535));
			end
			if (n % 100 == 0)
				idle_enabled = (n < RANDOM_WORDS - CALM_WORDS) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 15)
				addr = TAG_W'($urandom_range(0, 65535));
			else
				addr = working_set[$urandom_range(0, set_size - 1)];
			send_access(addr, 1'($urandom));
		end
	endtask

	initial begin
		@(posedge arst_n);
		test_fill_phase();
		test_hits();
		test_replacement();
		test_random_traffic();
		@(negedge clk) start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 4) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### page_replacement_oldest_unreferenced_core.f
sv/por_pkg.sv
sv/por_cell.sv
sv/por_ctrl.sv
sv/page_replacement_oldest_unreferenced_core.sv
sv/por_chk.sv
tb/sv/testbench.sv
